@@ src/swm_pkg.sv @@
// shared types and constants for the sliding window minimum block
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_BITS    = 32;
  localparam int STAMP_BITS     = 16;
  localparam int WLEN_BITS      = 9;
  localparam int MAX_WINDOW_DEF = 256;

  typedef struct packed {
    logic [STAMP_BITS-1:0]         expiry;
    logic signed [SAMPLE_BITS-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

@@ src/sliding_window_minimum_top.sv @@
// sliding window minimum over an ascending-minima ring held in one memory
// a series start completes from IDLE; otherwise the head entry is read (HEAD),
// retired and the next one read if it expires, then, unless the sample settles
// at the head, ring entries are examined on a backward walk from the tail (WALK)
// one sample is taken at a time (in_tready only in IDLE); each entry popped at most once
// reset: control, indices, sample count cleared, window length 1; ring not cleared
`default_nettype none

module sliding_window_minimum_top
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [SAMPLE_BITS-1:0] in_tdata,   // sample
  input  wire                    in_tuser,   // series_start
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [SAMPLE_BITS-1:0] out_tdata,  // window_min
  input  wire                    cfg_we,
  input  wire  [WLEN_BITS-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CW    = ((IDX_W > WLEN_BITS) ? IDX_W : WLEN_BITS) + 1;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx,
                                                input logic [WLEN_BITS-1:0] kk);
    logic [CW-1:0] nx;
    nx = CW'(idx) + CW'(1);
    return (nx >= CW'(kk)) ? '0 : nx[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx,
                                                input logic [WLEN_BITS-1:0] kk);
    logic [CW-1:0] last;
    last = CW'(kk) - CW'(1);
    return (idx == '0 || CW'(idx) >= CW'(kk)) ? last[IDX_W-1:0] : idx - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_fix(input logic [IDX_W-1:0] idx,
                                                input logic [WLEN_BITS-1:0] kk);
    return (CW'(idx) >= CW'(kk)) ? '0 : idx;
  endfunction

  state_t                        state_r, state_nxt;
  logic [WLEN_BITS-1:0]          wl_r, wl_nxt;
  logic [IDX_W-1:0]              head_r, head_nxt;
  logic [IDX_W-1:0]              tail_r, tail_nxt;
  logic [STAMP_BITS-1:0]         cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic signed [SAMPLE_BITS-1:0] s_r, s_nxt;
  logic [IDX_W-1:0]              h_r, h_nxt;
  logic [IDX_W-1:0]              t_r, t_nxt;
  logic signed [SAMPLE_BITS-1:0] hv_r, hv_nxt;
  logic                          retired_r, retired_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;

  entry_t                        ring_mem [MAX_WINDOW];
  entry_t                        rd_q;
  logic                          mem_we, mem_re;
  logic [IDX_W-1:0]              mem_waddr, mem_raddr;
  entry_t                        mem_wdata;

  logic [WLEN_BITS-1:0]          k;
  logic [IDX_W-1:0]              h0, t0, h_inc, t_dec, app_t, app_slot;
  logic [STAMP_BITS-1:0]         stamp;
  logic signed [SAMPLE_BITS-1:0] s_in, hv_cur, fin_val;
  logic                          accept, out_free, retire, le_head, ge_tail, walk_more;
  logic                          fin, app;

  // ring size in force
  always_comb begin
    if (wl_r == '0) begin
      k = WLEN_BITS'(1);
    end else if (CW'(wl_r) > CW'(MAX_WINDOW)) begin
      k = WLEN_BITS'(MAX_WINDOW);
    end else begin
      k = wl_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign s_in       = $signed(in_tdata);
  assign h0         = ring_fix(head_r, k);
  assign t0         = ring_fix(tail_r, k);
  assign h_inc      = ring_inc(h_r, k);
  assign t_dec      = ring_dec(t_r, k);
  assign stamp      = cnt_r + STAMP_BITS'(k);
  assign retire     = !retired_r && (rd_q.expiry == cnt_r);
  assign le_head    = (s_r <= rd_q.value);
  assign ge_tail    = (rd_q.value >= s_r);
  assign walk_more  = ge_tail && (t_dec != h_r);
  assign hv_cur     = (state_r == ST_HEAD) ? rd_q.value : hv_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // completion and append decisions
  always_comb begin
    fin     = 1'b0;
    app     = 1'b0;
    app_t   = h_r;
    fin_val = s_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_tuser) begin
          fin     = 1'b1;
          fin_val = s_in;
        end
      end
      ST_HEAD: begin
        if (!retire) begin
          if (le_head) begin
            fin = 1'b1;
          end else if (t_r == h_r) begin
            app   = 1'b1;
            fin   = 1'b1;
            app_t = h_r;
          end
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          app   = 1'b1;
          fin   = 1'b1;
          app_t = ge_tail ? t_dec : t_r;
        end
      end
      ST_HOLD: begin
        fin = 1'b0;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    app_slot = ring_inc(app_t, k);
    if (app) begin
      fin_val = (app_slot == h_r) ? s_r : hv_cur;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (fin) begin
      state_nxt = out_free ? ST_IDLE : ST_HOLD;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_nxt = ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (!retire) begin
            state_nxt = ST_WALK;
          end
        end
        ST_WALK: begin
          state_nxt = ST_WALK;
        end
        ST_HOLD: begin
          if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // datapath and memory control
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = app_slot;
    mem_wdata.expiry = stamp;
    mem_wdata.value  = s_r;
    mem_re           = 1'b0;
    mem_raddr        = h0;
    wl_nxt           = cfg_we ? cfg_wdata : wl_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    cnt_nxt          = cnt_r;
    s_nxt            = s_r;
    h_nxt            = h_r;
    t_nxt            = t_r;
    hv_nxt           = hv_r;
    retired_nxt      = retired_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            mem_we           = 1'b1;
            mem_waddr        = '0;
            mem_wdata.expiry = STAMP_BITS'(k);
            mem_wdata.value  = s_in;
            head_nxt         = '0;
            tail_nxt         = '0;
            cnt_nxt          = '0;
          end else begin
            cnt_nxt     = cnt_r + STAMP_BITS'(1);
            s_nxt       = s_in;
            h_nxt       = h0;
            t_nxt       = t0;
            retired_nxt = 1'b0;
            mem_re      = 1'b1;
            mem_raddr   = h0;
          end
        end
      end
      ST_HEAD: begin
        if (retire) begin
          h_nxt       = h_inc;
          retired_nxt = 1'b1;
          mem_re      = 1'b1;
          mem_raddr   = h_inc;
        end else if (le_head) begin
          mem_we    = 1'b1;
          mem_waddr = h_r;
          head_nxt  = h_r;
          tail_nxt  = h_r;
        end else begin
          hv_nxt = rd_q.value;
          if (app) begin
            mem_we    = 1'b1;
            mem_waddr = app_slot;
            head_nxt  = h_r;
            tail_nxt  = app_slot;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = t_r;
          end
        end
      end
      ST_WALK: begin
        if (app) begin
          mem_we    = 1'b1;
          mem_waddr = app_slot;
          head_nxt  = h_r;
          tail_nxt  = app_slot;
        end else begin
          t_nxt     = t_dec;
          mem_re    = 1'b1;
          mem_raddr = t_dec;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fin_val;
      end else begin
        res_nxt = fin_val;
      end
    end
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= ring_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= WLEN_BITS'(1);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    h_r        <= h_nxt;
    t_r        <= t_nxt;
    hv_r       <= hv_nxt;
    retired_r  <= retired_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // series start leaves a one-entry ring at slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser |=> head_r == '0 && tail_r == '0 && cnt_r == '0)
    else $error("series start did not reset ring indices");

  // the backward walk never reaches the head entry
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> t_r != h_r)
    else $error("tail walk reached head entry");

  // read and write of the ring never share a cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("ring read and write in the same cycle");

  // a held result leaves only when the output register frees up
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD && !out_free |=> state_r == ST_HOLD && $stable(res_r))
    else $error("held result lost");

endmodule

`default_nettype wire

@@ tb/sv/sliding_window_minimum_top_tb.sv @@
// self-checking testbench for the sliding window minimum block
`timescale 1ns / 1ps

import swm_pkg::*;

class window_min_board;
  bit signed [SAMPLE_BITS-1:0] ring_value [MAX_WINDOW_DEF];
  bit [STAMP_BITS-1:0]         ring_expiry [MAX_WINDOW_DEF];
  int unsigned                 head_idx;
  int unsigned                 tail_idx;
  bit [STAMP_BITS-1:0]         sample_count;
  bit [WLEN_BITS-1:0]          window_len = 1;
  bit [SAMPLE_BITS-1:0]        expected_min [$];
  int unsigned                 mismatches;
  int unsigned                 results_seen;

  function int unsigned ring_len();
    if (window_len < 1) return 1;
    if (window_len > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return window_len;
  endfunction

  function void set_window(bit [WLEN_BITS-1:0] v);
    window_len = v;
  endfunction

  function int unsigned pending();
    return expected_min.size();
  endfunction

  function void note_sample(bit signed [SAMPLE_BITS-1:0] s, bit first);
    int unsigned k;
    int unsigned h;
    int unsigned t;
    k = ring_len();
    if (head_idx >= k) head_idx = 0;
    if (tail_idx >= k) tail_idx = 0;
    if (first) begin
      sample_count = 0;
      head_idx = 0;
      tail_idx = 0;
      ring_value[0] = s;
      ring_expiry[0] = k[STAMP_BITS-1:0];
      expected_min.push_back(s);
      return;
    end
    sample_count = sample_count + 1'b1;
    h = head_idx;
    t = tail_idx;
    // retire the head once it falls out of the window
    if (ring_expiry[h] == sample_count) h = (h + 1 >= k) ? 0 : h + 1;
    if (s <= ring_value[h]) begin
      ring_value[h] = s;
      ring_expiry[h] = sample_count + k[STAMP_BITS-1:0];
      t = h;
    end else begin
      while (t != h && ring_value[t] >= s) t = (t == 0 || t >= k) ? k - 1 : t - 1;
      t = (t + 1 >= k) ? 0 : t + 1;
      ring_value[t] = s;
      ring_expiry[t] = sample_count + k[STAMP_BITS-1:0];
    end
    head_idx = h;
    tail_idx = t;
    expected_min.push_back(ring_value[h]);
  endfunction

  function void check_result(logic [SAMPLE_BITS-1:0] actual);
    bit [SAMPLE_BITS-1:0] want;
    results_seen++;
    if (expected_min.size() == 0) begin
      mismatches++;
      $error("window_min: expected nothing, actual %0d", $signed(actual));
      return;
    end
    want = expected_min.pop_front();
    if (actual !== want) begin
      mismatches++;
      $error("window_min: expected %0d, actual %0d", $signed(want), $signed(actual));
    end
  endfunction

  function void check_drained();
    if (expected_min.size() != 0) begin
      mismatches += expected_min.size();
      $error("window_min: expected %0d more results, actual none", expected_min.size());
    end
  endfunction
endclass

module sliding_window_minimum_top_tb;

  typedef enum {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef enum {
    DATA_FULL,
    DATA_NARROW,
    DATA_CORNER,
    DATA_RISING,
    DATA_FALLING
  } data_kind_e;

  localparam bit signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam bit signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam real         RUN_LIMIT_NS  = 60_000_000.0;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [SAMPLE_BITS-1:0] in_tdata = '0;   // sample
  logic                   in_tuser = 1'b0; // series_start
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_tdata;       // window_min
  logic                   cfg_we = 1'b0;
  logic [WLEN_BITS-1:0]   cfg_wdata = '0;

  window_min_board board = new;

  int          sender_idle_pct;
  int          recv_stall_pct;
  int          ramp_level;
  int unsigned samples_sent;
  int unsigned series_started;
  int unsigned window_writes;
  int unsigned random_items;

  sliding_window_minimum_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        sender_idle_pct = 31;
        recv_stall_pct  = 59;
      end
      IDLE_SENDER_HEAVY: begin
        sender_idle_pct = 59;
        recv_stall_pct  = 31;
      end
      default: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
    endcase
  endtask

  task automatic send_item(bit signed [SAMPLE_BITS-1:0] s, bit first);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_sample(s, first);
    samples_sent++;
    if (first) series_started++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // only while nothing is in flight
  task automatic write_window(bit [WLEN_BITS-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_window(v);
    window_writes++;
  endtask

  function automatic bit signed [SAMPLE_BITS-1:0] pick_sample(data_kind_e kind);
    case (kind)
      DATA_FULL:   return $urandom;
      DATA_NARROW: return $signed($urandom_range(16)) - 8;
      DATA_CORNER: begin
        case ($urandom_range(3))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      DATA_RISING: begin
        ramp_level += $urandom_range(3);
        return ramp_level;
      end
      default: begin
        ramp_level -= $urandom_range(3);
        return ramp_level;
      end
    endcase
  endfunction

  function automatic bit [WLEN_BITS-1:0] pick_window();
    case ($urandom_range(12))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 3;
      4:       return 4;
      5:       return 7;
      6:       return 16;
      7:       return 33;
      8:       return 100;
      9:       return 255;
      10:      return 256;
      11:      return 511;
      default: return $urandom_range(1, 511);
    endcase
  endfunction

  // every series opens with a start so no unwritten ring entry is ever read
  task automatic random_phase(int unsigned n_items, bit [WLEN_BITS-1:0] wlen, bit restarts);
    data_kind_e phase_kind;
    data_kind_e kind;
    bit         first;
    write_window(wlen);
    phase_kind = data_kind_e'($urandom_range(4));
    ramp_level = $urandom;
    for (int unsigned i = 0; i < n_items; i++) begin
      first = (i == 0) || (restarts && $urandom_range(24) == 0);
      kind  = ($urandom_range(9) < 7) ? phase_kind : data_kind_e'($urandom_range(4));
      send_item(pick_sample(kind), first);
      if ($urandom_range(59) == 0) drain();
    end
  endtask

  initial begin
    set_idling(IDLE_SENDER_LIGHT);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // window of one straight out of reset
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(0, 1'b0);

    // zero clamps to one
    write_window(0);
    send_item(-1, 1'b1);
    send_item(5, 1'b0);

    // equal pops, head expiry, head replacement
    write_window(4);
    send_item(10, 1'b1);
    send_item(20, 1'b0);
    send_item(30, 1'b0);
    send_item(20, 1'b0);
    send_item(40, 1'b0);
    send_item(50, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b0);

    // oversize clamps to the full ring, tail walk back to the head
    write_window(511);
    send_item(0, 1'b1);
    send_item(100, 1'b0);
    send_item(200, 1'b0);
    send_item(300, 1'b0);
    send_item(50, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);

    // back-to-back series starts
    write_window(2);
    send_item(3, 1'b1);
    send_item(2, 1'b1);
    send_item(2, 1'b0);
    send_item(1, 1'b0);

    while (random_items < RANDOM_ITEMS) begin
      int unsigned n;
      if (random_items < RANDOM_ITEMS / 3) set_idling(IDLE_SENDER_LIGHT);
      else if (random_items < 2 * RANDOM_ITEMS / 3) set_idling(IDLE_SENDER_HEAVY);
      else set_idling(IDLE_NONE);
      n = $urandom_range(30, 90);
      random_phase(n, pick_window(), 1'b1);
      random_items += n;
    end

    drain();
    repeat (10) @(posedge clk);
    board.check_drained();
    $display("ran %0d samples in %0d series across %0d window writes (0 to 511)",
             samples_sent, series_started, window_writes);
    $display("compared %0d minima under sender and receiver stalls and full drains",
             board.results_seen);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/swm_pkg.sv
src/sliding_window_minimum_top.sv
tb/sv/sliding_window_minimum_top_tb.sv
